FILE: rtl/core/hcb_pkg.sv
// shared types, codes and rom contents for the home computer bus block
package hcb_pkg;

  localparam int unsigned MAIN_DEPTH  = 65536;
  localparam int unsigned VIDEO_DEPTH = 64;
  localparam int unsigned BYTE_W      = 8;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] ROUTE_INSIDE  = 2'd0;
  localparam logic [1:0] ROUTE_SOUND   = 2'd1;
  localparam logic [1:0] ROUTE_TIMER_A = 2'd2;
  localparam logic [1:0] ROUTE_TIMER_B = 2'd3;

  localparam logic [1:0] CFG_ROMS  = 2'd0;
  localparam logic [1:0] CFG_LINE  = 2'd1;
  localparam logic [1:0] CFG_FRAME = 2'd2;

  localparam logic [5:0] VREG_CTRL1  = 6'h11;
  localparam logic [5:0] VREG_RASTER = 6'h12;
  localparam logic [5:0] VREG_FLAGS  = 6'h19;
  localparam logic [5:0] VREG_ENABLE = 6'h1A;

  localparam logic [7:0] PORT_DIR_RESET  = 8'h2F;
  localparam logic [7:0] PORT_OUT_RESET  = 8'h37;
  localparam logic [7:0] LINE_CYC_RESET  = 8'd63;
  localparam logic [8:0] FRAME_LIN_RESET = 9'd312;

  localparam logic [7:0] KEY_KERNAL = 8'hE5;
  localparam logic [7:0] KEY_BASIC  = 8'hA5;
  localparam logic [7:0] KEY_GLYPH  = 8'hC5;

  typedef enum logic [3:0] {
    SRC_DIR,
    SRC_PORT,
    SRC_KERNAL,
    SRC_BASIC,
    SRC_GLYPH,
    SRC_VIDEO,
    SRC_FWD,
    SRC_NONE,
    SRC_RAM
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [1:0] route;
    logic [4:0] offset;
    logic [7:0] eff;
  } decode_t;

  function automatic logic [7:0] image_byte(logic [12:0] i, logic [7:0] key);
    image_byte = i[7:0] ^ {3'b000, i[12:8]} ^ key;
  endfunction

endpackage

FILE: rtl/core/hcb_if.sv
// valid/ready channel interfaces for requests, responses and configuration
interface hcb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  tick_cycles;

  modport source (output valid, req_type, address, write_data, tick_cycles, input ready);
  modport sink (input valid, req_type, address, write_data, tick_cycles, output ready);
endinterface

interface hcb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] route;
  logic [4:0] device_offset;
  logic       irq_out;

  modport source (output valid, read_data, route, device_offset, irq_out, input ready);
  modport sink (input valid, read_data, route, device_offset, irq_out, output ready);
endinterface

interface hcb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/home_computer_bus_with_raster_irq.sv
// top level: banked bus with 64k ram, rom images, video registers and raster irq
//
// channels: req takes bus reads, bus writes and ticks; rsp returns one result
// per request (read byte, forward route and offset, irq level); cfg writes
// roms_present, line_cycles and frame_lines and is always ready.
// a request transfers only in the idle state. the ram is read at the transfer
// edge into its read register; in the exec state the result register loads
// once rsp is free, rsp valid rises and the block returns to idle, so it takes
// no new request until the last one has its result. a tick first stays in exec
// while it advances the raster line counter, which steps one line a cycle.
// the result sits in an output register, so the next request can transfer
// while the previous result still waits; when the receiver stalls with a
// result pending, the block holds its next result and takes no new request
// until rsp frees up.
// after reset the block sweeps ram and the video registers to zero, one entry
// a cycle, over all 65536 ram entries before it takes its first request;
// config writes are taken during the sweep. reset sets the processor port to
// 0x2f/0x37, clears raster state and irq, line_cycles 63 and frame_lines 312.
module home_computer_bus_with_raster_irq (
  input  logic          clk,
  input  logic          rst,
  hcb_req_if.sink       req,
  hcb_rsp_if.source     rsp,
  hcb_cfg_if.sink       cfg
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  localparam int unsigned MAIN_AW  = $clog2(hcb_pkg::MAIN_DEPTH);
  localparam int unsigned VIDEO_AW = $clog2(hcb_pkg::VIDEO_DEPTH);

  logic [1:0]         state;
  logic [MAIN_AW-1:0] clr_cnt;
  logic [7:0]         port_dir;
  logic [7:0]         port_out;
  logic               roms_present;
  logic [7:0]         line_cycles;
  logic [8:0]         frame_lines;
  logic [8:0]         raster_line;
  logic [8:0]         raster_compare;
  logic [7:0]         cycle_accum;
  logic               irq;
  logic               irq_en;
  logic [1:0]         item_type;
  logic [15:0]        item_addr;
  logic [8:0]         acc;

  logic [15:0]        cur_addr;
  hcb_pkg::decode_t   dec;
  logic               clearing;
  logic               accept;
  logic               acc_write;
  logic               ram_wen;
  logic               vid_wen;
  logic [7:0]         main_rdata;
  logic [7:0]         vid_rdata;
  logic [7:0]         per;
  logic               acc_ge;
  logic [8:0]         line_inc;
  logic [8:0]         line_next;
  logic               out_free;
  logic [7:0]         rd_byte;
  logic [5:0]         vidx;
  logic               rsp_load;
  logic               fwd_item;

  assign clearing  = (state == ST_CLEAR);
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign acc_write = accept && (req.req_type == hcb_pkg::REQ_WRITE);
  assign cur_addr  = (state == ST_IDLE) ? req.address : item_addr;
  assign vidx      = item_addr[5:0];
  assign out_free  = !rsp.valid || rsp.ready;

  hcb_decode u_decode (
    .roms_present (roms_present),
    .port_dir     (port_dir),
    .port_out     (port_out),
    .address      (cur_addr),
    .dec          (dec)
  );

  assign ram_wen = clearing ||
                   (acc_write && (dec.src == hcb_pkg::SRC_RAM ||
                                  dec.src == hcb_pkg::SRC_KERNAL ||
                                  dec.src == hcb_pkg::SRC_BASIC ||
                                  dec.src == hcb_pkg::SRC_GLYPH));
  assign vid_wen = clearing ||
                   (acc_write && dec.src == hcb_pkg::SRC_VIDEO &&
                    req.address[5:0] != hcb_pkg::VREG_FLAGS);

  hcb_ram #(
    .WIDTH (hcb_pkg::BYTE_W),
    .DEPTH (hcb_pkg::MAIN_DEPTH)
  ) u_main_ram (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (clearing ? clr_cnt : req.address),
    .wdata (clearing ? 8'd0 : req.write_data),
    .raddr (cur_addr),
    .rdata (main_rdata)
  );

  hcb_ram #(
    .WIDTH (hcb_pkg::BYTE_W),
    .DEPTH (hcb_pkg::VIDEO_DEPTH)
  ) u_video_ram (
    .clk   (clk),
    .wen   (vid_wen),
    .waddr (clearing ? clr_cnt[VIDEO_AW-1:0] : req.address[VIDEO_AW-1:0]),
    .wdata (clearing ? 8'd0 : req.write_data),
    .raddr (cur_addr[VIDEO_AW-1:0]),
    .rdata (vid_rdata)
  );

  // raster line step
  assign per       = (line_cycles == 8'd0) ? 8'd1 : line_cycles;
  assign acc_ge    = acc >= {1'b0, per};
  assign line_inc  = raster_line + 9'd1;
  assign line_next = (line_inc >= frame_lines) ? 9'd0 : line_inc;

  assign rsp_load = (state == ST_EXEC) &&
                    !(item_type == hcb_pkg::REQ_TICK && acc_ge) && out_free;
  assign fwd_item = (item_type == hcb_pkg::REQ_READ || item_type == hcb_pkg::REQ_WRITE) &&
                    dec.src == hcb_pkg::SRC_FWD;

  always_comb begin
    rd_byte = 8'd0;
    unique case (dec.src)
      hcb_pkg::SRC_DIR:    rd_byte = port_dir;
      hcb_pkg::SRC_PORT:   rd_byte = dec.eff;
      hcb_pkg::SRC_KERNAL: rd_byte = hcb_pkg::image_byte(item_addr[12:0], hcb_pkg::KEY_KERNAL);
      hcb_pkg::SRC_BASIC:  rd_byte = hcb_pkg::image_byte(item_addr[12:0], hcb_pkg::KEY_BASIC);
      hcb_pkg::SRC_GLYPH:  rd_byte = hcb_pkg::image_byte({1'b0, item_addr[11:0]},
                                                         hcb_pkg::KEY_GLYPH);
      hcb_pkg::SRC_VIDEO: begin
        if (vidx == hcb_pkg::VREG_RASTER) begin
          rd_byte = raster_line[7:0];
        end else if (vidx == hcb_pkg::VREG_CTRL1) begin
          rd_byte = {raster_line[8], vid_rdata[6:0]};
        end else if (vidx == hcb_pkg::VREG_FLAGS) begin
          rd_byte = {7'd0, irq};
        end else begin
          rd_byte = vid_rdata;
        end
      end
      hcb_pkg::SRC_FWD:    rd_byte = 8'd0;
      hcb_pkg::SRC_NONE:   rd_byte = 8'd0;
      hcb_pkg::SRC_RAM:    rd_byte = main_rdata;
      default:             rd_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_cnt        <= '0;
      port_dir       <= hcb_pkg::PORT_DIR_RESET;
      port_out       <= hcb_pkg::PORT_OUT_RESET;
      roms_present   <= 1'b0;
      line_cycles    <= hcb_pkg::LINE_CYC_RESET;
      frame_lines    <= hcb_pkg::FRAME_LIN_RESET;
      raster_line    <= 9'd0;
      raster_compare <= 9'd0;
      cycle_accum    <= 8'd0;
      irq            <= 1'b0;
      irq_en         <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          hcb_pkg::CFG_ROMS:  roms_present <= cfg.data[0];
          hcb_pkg::CFG_LINE:  line_cycles  <= cfg.data[7:0];
          hcb_pkg::CFG_FRAME: frame_lines  <= cfg.data;
          default: ;
        endcase
      end

      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item_type <= req.req_type;
            item_addr <= req.address;
            acc       <= {1'b0, cycle_accum} + {1'b0, req.tick_cycles};
            state     <= ST_EXEC;
            if (req.req_type == hcb_pkg::REQ_WRITE) begin
              if (dec.src == hcb_pkg::SRC_DIR) begin
                port_dir <= req.write_data;
              end else if (dec.src == hcb_pkg::SRC_PORT) begin
                port_out <= req.write_data;
              end else if (dec.src == hcb_pkg::SRC_VIDEO) begin
                // only flag bit 0 can ever be set, so it tracks the irq line
                if (req.address[5:0] == hcb_pkg::VREG_FLAGS) begin
                  irq <= irq & ~req.write_data[0];
                end
                if (req.address[5:0] == hcb_pkg::VREG_CTRL1) begin
                  raster_compare[8] <= req.write_data[7];
                end
                if (req.address[5:0] == hcb_pkg::VREG_RASTER) begin
                  raster_compare[7:0] <= req.write_data;
                end
                if (req.address[5:0] == hcb_pkg::VREG_ENABLE) begin
                  irq_en <= req.write_data[0];
                end
              end
            end
          end
        end
        ST_EXEC: begin
          if (item_type == hcb_pkg::REQ_TICK && acc_ge) begin
            acc         <= acc - {1'b0, per};
            raster_line <= line_next;
            if (irq_en && line_next == raster_compare) begin
              irq <= 1'b1;
            end
          end else if (out_free) begin
            rsp.irq_out       <= irq;
            rsp.read_data     <= (item_type == hcb_pkg::REQ_READ) ? rd_byte : 8'd0;
            rsp.route         <= fwd_item ? dec.route : hcb_pkg::ROUTE_INSIDE;
            rsp.device_offset <= fwd_item ? dec.offset : 5'd0;
            if (item_type == hcb_pkg::REQ_TICK) begin
              cycle_accum <= acc[7:0];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/hcb_ram.sv
// generic simple dual port ram with registered read
module hcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/hcb_decode.sv
// bank and i/o decode from the bus address and the effective port value
module hcb_decode (
  input  logic                 roms_present,
  input  logic [7:0]           port_dir,
  input  logic [7:0]           port_out,
  input  logic [15:0]          address,
  output hcb_pkg::decode_t     dec
);

  logic [7:0] eff;
  logic       lo_ram;
  logic       hi_ram;
  logic       char_en;
  logic       io_on;
  logic       glyph_on;

  assign eff      = port_out | ~port_dir;
  assign lo_ram   = eff[0];
  assign hi_ram   = eff[1];
  assign char_en  = eff[2];
  assign io_on    = char_en && (lo_ram || hi_ram);
  assign glyph_on = roms_present && !char_en && (lo_ram || hi_ram);

  always_comb begin
    dec.eff    = eff;
    dec.src    = hcb_pkg::SRC_RAM;
    dec.route  = hcb_pkg::ROUTE_INSIDE;
    dec.offset = 5'd0;
    priority if (address == 16'h0000) begin
      dec.src = hcb_pkg::SRC_DIR;
    end else if (address == 16'h0001) begin
      dec.src = hcb_pkg::SRC_PORT;
    end else if (address[15:13] == 3'b111 && roms_present && hi_ram) begin
      dec.src = hcb_pkg::SRC_KERNAL;
    end else if (address[15:13] == 3'b101 && roms_present && lo_ram && hi_ram) begin
      dec.src = hcb_pkg::SRC_BASIC;
    end else if (address[15:12] == 4'hD && io_on) begin
      priority if (address[11:6] == 6'd0) begin
        dec.src = hcb_pkg::SRC_VIDEO;
      end else if (address[11:5] == 7'b0100_000) begin
        dec.src    = hcb_pkg::SRC_FWD;
        dec.route  = hcb_pkg::ROUTE_SOUND;
        dec.offset = address[4:0];
      end else if (address[11:8] == 4'hC) begin
        dec.src    = hcb_pkg::SRC_FWD;
        dec.route  = hcb_pkg::ROUTE_TIMER_A;
        dec.offset = {1'b0, address[3:0]};
      end else if (address[11:8] == 4'hD) begin
        dec.src    = hcb_pkg::SRC_FWD;
        dec.route  = hcb_pkg::ROUTE_TIMER_B;
        dec.offset = {1'b0, address[3:0]};
      end else begin
        dec.src = hcb_pkg::SRC_NONE;
      end
    end else if (address[15:12] == 4'hD && glyph_on) begin
      dec.src = hcb_pkg::SRC_GLYPH;
    end else begin
      dec.src = hcb_pkg::SRC_RAM;
    end
  end

endmodule
